[hdl/jtss_pkg.sv]
`default_nettype none
package jtss_pkg;

   // depth counter width default
   localparam int DepthBitsDefault = 8;

   // entries of the word queue between front and back
   localparam int QueueDepth = 2;
   localparam int QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW = $clog2(QueueDepth + 1);

   typedef enum logic [4:0] {
      StError      = 5'd0,
      StDoneStr    = 5'd1,
      StDqH3       = 5'd2,
      StDqH2       = 5'd3,
      StDqH1       = 5'd4,
      StDqH0       = 5'd5,
      StDqEsc      = 5'd6,
      StDqStr      = 5'd7,
      StSqH3       = 5'd8,
      StSqH2       = 5'd9,
      StSqH1       = 5'd10,
      StSqH0       = 5'd11,
      StSqEsc      = 5'd12,
      StSqStr      = 5'd13,
      StZero       = 5'd14,
      StDigits     = 5'd15,
      StDigit      = 5'd16,
      StExp        = 5'd17,
      StFrac       = 5'd18,
      StFracDigits = 5'd19,
      StNonzero    = 5'd20,
      StNeg        = 5'd21,
      StKeyword    = 5'd22,
      StSpace      = 5'd23,
      StOpDone     = 5'd24,
      StStart      = 5'd25
   } lex_state_type;

   // transition codes: bit 5 marks a token end, bit 2 a skipped run, the low two bits give the kind
   localparam logic [5:0] TokOp   = 6'd32;
   localparam logic [5:0] TokNum  = 6'd33;
   localparam logic [5:0] TokKw   = 6'd34;
   localparam logic [5:0] TokStr  = 6'd35;
   localparam logic [5:0] TokSkip = 6'd36;

   localparam logic [1:0] KindOp = 2'd0;

   localparam logic [7:0] ChBraceOpen    = 8'h7B;
   localparam logic [7:0] ChBraceClose   = 8'h7D;
   localparam logic [7:0] ChBracketOpen  = 8'h5B;
   localparam logic [7:0] ChBracketClose = 8'h5D;
   localparam logic [7:0] ChComma        = 8'h2C;
   localparam logic [7:0] ChColon        = 8'h3A;
   localparam logic [7:0] ChDquote       = 8'h22;
   localparam logic [7:0] ChSquote       = 8'h27;
   localparam logic [7:0] ChBackslash    = 8'h5C;
   localparam logic [7:0] ChSlash        = 8'h2F;
   localparam logic [7:0] ChMinus        = 8'h2D;
   localparam logic [7:0] ChPlus         = 8'h2B;
   localparam logic [7:0] ChDot          = 8'h2E;
   localparam logic [7:0] ChZero         = 8'h30;
   localparam logic [7:0] ChNul          = 8'h00;

   typedef enum logic [2:0] {
      DepthNone,
      DepthBraceInc,
      DepthBraceDec,
      DepthBracketInc,
      DepthBracketDec
   } depth_op_type;

   // word handed from the lexer front to the depth back end
   typedef struct packed {
      logic          token_done;
      logic [1:0]    token_kind;
      depth_op_type  depth_op;
      lex_state_type lex_state;
   } tok_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
   endfunction

   function automatic logic is_lower(logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic [5:0] st_code(lex_state_type s);
      return {1'b0, s};
   endfunction

   function automatic logic [5:0] ends_with(logic [7:0] c, logic [5:0] code);
      return c[7] ? st_code(StError) : code;
   endfunction

   function automatic logic [5:0] esc_next(logic [7:0] c, lex_state_type str,
                                           lex_state_type hex0);
      logic [5:0] r;
      r = st_code(StError);
      if ((c == 8'h62) || (c == 8'h66) || (c == 8'h6E) || (c == 8'h72) ||
          (c == 8'h74) || (c == ChSquote) || (c == ChDquote) ||
          (c == ChBackslash) || (c == ChSlash)) begin
         r = st_code(str);
      end else if (c == 8'h75) begin
         r = st_code(hex0);
      end
      return r;
   endfunction

   function automatic logic [5:0] hex_step(logic [7:0] c, lex_state_type nxt);
      return is_hex(c) ? st_code(nxt) : st_code(StError);
   endfunction

   // one lexer transition
   function automatic logic [5:0] lex_next(lex_state_type s, logic [7:0] c);
      logic [5:0] r;
      r = st_code(StError);
      unique case (s)
         StDoneStr: r = ends_with(c, TokStr);
         StDqH3:    r = hex_step(c, StDqStr);
         StDqH2:    r = hex_step(c, StDqH3);
         StDqH1:    r = hex_step(c, StDqH2);
         StDqH0:    r = hex_step(c, StDqH1);
         StDqEsc:   r = esc_next(c, StDqStr, StDqH0);
         StDqStr: begin
            if (c == ChNul)            r = st_code(StError);
            else if (c == ChBackslash) r = st_code(StDqEsc);
            else if (c == ChDquote)    r = st_code(StDoneStr);
            else                       r = st_code(StDqStr);
         end
         StSqH3:    r = hex_step(c, StSqStr);
         StSqH2:    r = hex_step(c, StSqH3);
         StSqH1:    r = hex_step(c, StSqH2);
         StSqH0:    r = hex_step(c, StSqH1);
         StSqEsc:   r = esc_next(c, StSqStr, StSqH0);
         StSqStr: begin
            if (c == ChNul)            r = st_code(StError);
            else if (c == ChBackslash) r = st_code(StSqEsc);
            else if (c == ChSquote)    r = st_code(StDoneStr);
            else                       r = st_code(StSqStr);
         end
         StZero:    r = is_digit(c) ? st_code(StError) : ends_with(c, TokNum);
         StDigits:  r = is_digit(c) ? st_code(StDigits) : ends_with(c, TokNum);
         StDigit:   r = is_digit(c) ? st_code(StDigits) : st_code(StError);
         StExp: begin
            if ((c == ChMinus) || (c == ChPlus)) r = st_code(StDigit);
            else if (is_digit(c))                r = st_code(StDigits);
            else                                 r = st_code(StError);
         end
         StFrac:    r = is_digit(c) ? st_code(StFracDigits) : st_code(StError);
         StFracDigits: begin
            if (is_digit(c))                     r = st_code(StFracDigits);
            else if ((c == 8'h65) || (c == 8'h45)) r = st_code(StExp);
            else                                 r = ends_with(c, TokNum);
         end
         StNonzero: begin
            if (is_digit(c))                     r = st_code(StNonzero);
            else if ((c == 8'h65) || (c == 8'h45)) r = st_code(StExp);
            else if (c == ChDot)                 r = st_code(StFrac);
            else                                 r = ends_with(c, TokNum);
         end
         StNeg: begin
            if ((c >= 8'h31) && (c <= 8'h39)) r = st_code(StNonzero);
            else                              r = st_code(StError);
         end
         StKeyword: r = is_lower(c) ? st_code(StKeyword) : ends_with(c, TokKw);
         StSpace:   r = is_space(c) ? st_code(StSpace) : ends_with(c, TokSkip);
         StOpDone:  r = ends_with(c, TokOp);
         StStart: begin
            if (c == ChDquote)                        r = st_code(StDqStr);
            else if (c == ChSquote)                   r = st_code(StSqStr);
            else if (c == ChZero)                     r = st_code(StZero);
            else if ((c >= 8'h31) && (c <= 8'h39))    r = st_code(StNonzero);
            else if (c == ChMinus)                    r = st_code(StNeg);
            else if ((c == ChBraceOpen) || (c == ChBraceClose) ||
                     (c == ChBracketOpen) || (c == ChBracketClose) ||
                     (c == ChComma) || (c == ChColon)) r = st_code(StOpDone);
            else if (is_lower(c))                     r = st_code(StKeyword);
            else if (is_space(c))                     r = st_code(StSpace);
            else                                      r = st_code(StError);
         end
         default:   r = st_code(StError);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/jtss_ifs.sv]
`default_nettype none
// byte channel into the splitter
interface jtss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;

   modport source (output valid, output byte_req, input ready);
   modport sink   (input valid, input byte_req, output ready);
endinterface

// token result channel
interface jtss_rsp_if;
   logic              valid;
   logic              ready;
   logic              token_done;
   logic [1:0]        token_kind;
   logic              message_done;
   logic              fault;
   logic [4:0]        lexer_state_out;
   logic signed [7:0] brace_depth;
   logic signed [7:0] bracket_depth;

   modport source (output valid, output token_done, output token_kind,
                   output message_done, output fault, output lexer_state_out,
                   output brace_depth, output bracket_depth, input ready);
   modport sink   (input valid, input token_done, input token_kind,
                   input message_done, input fault, input lexer_state_out,
                   input brace_depth, input bracket_depth, output ready);
endinterface
`default_nettype wire

[hdl/jtss_front.sv]
`default_nettype none
module jtss_front import jtss_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   jtss_req_if.sink    req_ch,
   input  wire logic   queue_full,
   output logic        push,
   output tok_word_type push_word
);

   lex_state_type state_ff, state_in;
   logic [7:0]    first_ff, first_in;
   logic [5:0]    nx;
   logic [5:0]    restart;
   logic          accept;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept;

   always_comb begin
      nx        = lex_next(state_ff, req_ch.byte_req);
      restart   = lex_next(StStart, req_ch.byte_req);
      first_in  = first_ff;
      state_in  = lex_state_type'(nx[4:0]);
      push_word = '0;
      push_word.depth_op = DepthNone;
      if (nx[5]) begin
         // token ended: report it unless it is a whitespace run, then rerun this byte from start
         push_word.token_done = !nx[2];
         push_word.token_kind = nx[2] ? KindOp : nx[1:0];
         if (!nx[2] && (nx[1:0] == KindOp)) begin
            unique case (first_ff)
               ChBraceOpen:    push_word.depth_op = DepthBraceInc;
               ChBraceClose:   push_word.depth_op = DepthBraceDec;
               ChBracketOpen:  push_word.depth_op = DepthBracketInc;
               ChBracketClose: push_word.depth_op = DepthBracketDec;
               default:        push_word.depth_op = DepthNone;
            endcase
         end
         state_in = lex_state_type'(restart[4:0]);
         first_in = req_ch.byte_req;
      end else if ((state_ff == StStart) && (nx != st_code(StError))) begin
         first_in = req_ch.byte_req;
      end
      push_word.lex_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StStart;
         first_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

endmodule
`default_nettype wire

[hdl/jtss_queue.sv]
`default_nettype none
module jtss_queue import jtss_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire tok_word_type  push_word,
   input  wire logic          pop,
   output tok_word_type       pop_word,
   output queue_stat_type     stat
);

   tok_word_type         slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == QueueCntW'(QueueDepth));
   assign stat.empty = (count_ff == '0);
   assign pop_word   = slot_ff[rd_ptr_ff];

   function automatic logic [QueuePtrW-1:0] ptr_inc(logic [QueuePtrW-1:0] p);
      return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_word;
   end

endmodule
`default_nettype wire

[hdl/jtss_back.sv]
`default_nettype none
module jtss_back import jtss_pkg::*; #(
   parameter int DEPTH_BITS = DepthBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_stat_type queue_stat,
   input  wire tok_word_type pop_word,
   output logic              pop,
   jtss_rsp_if.source        rsp_ch
);

   localparam int ExtW = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;
   localparam logic signed [DEPTH_BITS-1:0] LvlMax =
      signed'({1'b0, {(DEPTH_BITS-1){1'b1}}});
   localparam logic signed [DEPTH_BITS-1:0] LvlMin =
      signed'({1'b1, {(DEPTH_BITS-1){1'b0}}});

   logic signed [DEPTH_BITS-1:0] brace_ff, brace_in;
   logic signed [DEPTH_BITS-1:0] bracket_ff, bracket_in;
   logic signed [ExtW-1:0]       brace_ext, bracket_ext;
   logic                         valid_ff, valid_in;
   logic                         done_ff, msg_ff, fault_ff;
   logic [1:0]                   kind_ff;
   logic [4:0]                   state_ff;
   logic signed [7:0]            brace_out_ff, bracket_out_ff;

   assign pop = !queue_stat.empty && (!valid_ff || rsp_ch.ready);

   // saturating depth moves
   always_comb begin
      brace_in   = brace_ff;
      bracket_in = bracket_ff;
      case (pop_word.depth_op)
         DepthBraceInc:   if (brace_ff != LvlMax)   brace_in   = brace_ff + 1'b1;
         DepthBraceDec:   if (brace_ff != LvlMin)   brace_in   = brace_ff - 1'b1;
         DepthBracketInc: if (bracket_ff != LvlMax) bracket_in = bracket_ff + 1'b1;
         DepthBracketDec: if (bracket_ff != LvlMin) bracket_in = bracket_ff - 1'b1;
         default: ;
      endcase
      brace_ext   = ExtW'(brace_in);
      bracket_ext = ExtW'(bracket_in);
      valid_in    = pop ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         brace_ff   <= '0;
         bracket_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            brace_ff   <= brace_in;
            bracket_ff <= bracket_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         done_ff        <= pop_word.token_done;
         kind_ff        <= pop_word.token_kind;
         msg_ff         <= pop_word.token_done && (brace_in == '0) && (bracket_in == '0);
         fault_ff       <= (pop_word.lex_state == StError);
         state_ff       <= pop_word.lex_state;
         brace_out_ff   <= brace_ext[7:0];
         bracket_out_ff <= bracket_ext[7:0];
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.token_done      = done_ff;
   assign rsp_ch.token_kind      = kind_ff;
   assign rsp_ch.message_done    = msg_ff;
   assign rsp_ch.fault           = fault_ff;
   assign rsp_ch.lexer_state_out = state_ff;
   assign rsp_ch.brace_depth     = brace_out_ff;
   assign rsp_ch.bracket_depth   = bracket_out_ff;

endmodule
`default_nettype wire

[hdl/json_token_stream_splitter_unit.sv]
`default_nettype none
// json token stream splitter: takes one byte of json text per word on req_ch
// and returns one result word per byte on rsp_ch, in order. a token is
// reported on the byte after it ends (whitespace runs are not reported);
// operator tokens move saturating brace and bracket depths of DEPTH_BITS
// bits, and message_done marks a reported token that leaves both depths at
// zero. once the lexer falls into the error state every later result shows
// fault until reset. throughput is one byte per clock while the queue is not
// full, set by the lexer state register that closes on itself; a byte taken
// is classified and written into the queue, then loaded into the output
// register once rsp_ch can take a new word, and presented on rsp_ch from
// there. a two-word queue between front and back and the output register
// let the input keep flowing while a result waits.
module json_token_stream_splitter_unit import jtss_pkg::*; #(
   parameter int DEPTH_BITS = DepthBitsDefault
) (
   input  wire logic  clock,
   input  wire logic  reset,
   jtss_req_if.sink   req_ch,
   jtss_rsp_if.source rsp_ch
);

   // front to queue
   logic           push;
   tok_word_type   push_word;
   // queue to back
   logic           pop;
   tok_word_type   pop_word;
   queue_stat_type queue_stat;

   // lexer front: classifies each byte and tracks the token start byte
   jtss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .queue_full(queue_stat.full),
      .push      (push),
      .push_word (push_word)
   );

   // short queue decoupling the lexer from the result side
   jtss_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_word(push_word),
      .pop      (pop),
      .pop_word (pop_word),
      .stat     (queue_stat)
   );

   // back end: depth counters and the result register
   jtss_back #(
      .DEPTH_BITS(DEPTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_stat(queue_stat),
      .pop_word  (pop_word),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

   // depth only moves on a reported operator token
   a_op_needs_token: assert property (@(posedge clock) disable iff (reset)
      (push && !push_word.token_done) |-> (push_word.depth_op == DepthNone))
      else $error("depth move without a reported token");

   // the error state is sticky across consecutive words
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (push && (push_word.lex_state == StError)) |=>
      (!push || (push_word.lex_state == StError)))
      else $error("lexer left the error state");

   // the queue is never written while full unless a word is popped with it
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && queue_stat.full && !pop))
      else $error("queue overflow");

   // message end only comes with a reported token
   a_msg_with_token: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.token_done) |-> !rsp_ch.message_done)
      else $error("message end without token");

endmodule
`default_nettype wire
